/* rtl/i2csb_pkg.sv */
// Shared types, codes and constants of the I2C slave buffer pointer block.
// Depends on nothing; imported by every module of the block.
package i2csb_pkg;

  localparam int BUF_DEPTH = 8;
  localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;

  typedef enum logic [2:0] {
    OP_ADDR_RX = 3'd0,
    OP_DATA_RX = 3'd1,
    OP_TX_REQ  = 3'd2,
    OP_END     = 3'd3,
    OP_HOST_WR = 3'd4,
    OP_HOST_RD = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_NACK    = 2'd2,
    ACT_RELEASE = 2'd3
  } act_e;

  localparam logic [7:0] FLG_DATA  = 8'h02;
  localparam logic [7:0] FLG_ADDR  = 8'h04;
  localparam logic [7:0] FLG_FULL  = 8'h10;
  localparam logic [7:0] FLG_NOPTR = 8'h20;
  localparam logic [7:0] FLG_MORE  = 8'h40;
  localparam logic [7:0] FLG_LAST  = 8'h80;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] data_byte;
    logic [2:0] host_index;
    logic       hold_off;
  } item_t;

  typedef struct packed {
    act_e       bus_action;
    logic [7:0] send_byte;
    logic [7:0] event_flags;
    logic       rx_written;
    logic [7:0] host_data;
  } result_t;

  typedef struct packed {
    logic             ptr_valid;
    logic [PTR_W-1:0] ptr;
  } ptr_stat_t;

endpackage

/* rtl/i2c_slave_buffer_pointer.sv */
// Top level of the I2C slave buffer pointer block: input register, core, result register.
// Depends on i2csb_pkg, i2csb_in_stage, i2csb_core, i2csb_out_stage.
//
//   channel | direction | tdata (low bit up)                                   | tuser
//   s_axis  | in        | data_byte[7:0] host_index[10:8] hold_off[11]         | opcode
//   m_axis  | out       | bus_action[1:0] send_byte[9:2] event_flags[17:10]
//           |           | rx_written[18] host_data[26:19]                      | -
//
// One request per cycle while m_axis is ready; results leave from the result register.
// The request is decoded against pointer and stores in the cycle it leaves the
// input register; state commits on that same edge.
// Reset clears pointer, valid flag, both stores and both stage valids.
// A stalled m_axis holds the result; the input register then fills and s_axis stalls.
module i2c_slave_buffer_pointer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // data_byte[7:0], host_index[10:8], hold_off[11], zero fill
  input  logic [i2csb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [i2csb_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // bus_action[1:0], send_byte[9:2], event_flags[17:10], rx_written[18],
  // host_data[26:19], zero fill
  output logic [i2csb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import i2csb_pkg::*;

  item_t     in_item, st_item;
  logic      st_valid, out_ready, fire;
  result_t   core_res, out_res;
  ptr_stat_t stat;

  assign in_item = '{opcode:     op_e'(s_axis_tuser),
                     data_byte:  s_axis_tdata[7:0],
                     host_index: s_axis_tdata[10:8],
                     hold_off:   s_axis_tdata[11]};

  assign fire = st_valid && out_ready;

  i2csb_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (st_valid),
    .adv_i   (fire),
    .item_o  (st_item)
  );

  i2csb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (st_item),
    .res_o  (core_res),
    .stat_o (stat)
  );

  i2csb_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (core_res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.host_data, out_res.rx_written,
                         out_res.event_flags, out_res.send_byte, out_res.bus_action};

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.ptr_valid |-> ({1'b0, stat.ptr} < (PTR_W + 1)'(BUF_DEPTH)))
    else $error("pointer out of range while valid");

  a_ptr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.ptr_valid |-> (stat.ptr == '0))
    else $error("invalid pointer not cleared");

  a_wr_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.rx_written) |->
      (out_res.bus_action == ACT_ACK || out_res.bus_action == ACT_NACK))
    else $error("receive write without ack or nack");

  a_full_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (core_res.event_flags & (FLG_FULL | FLG_LAST)) != 8'd0) |=>
      !stat.ptr_valid)
    else $error("pointer still valid after end of store");

endmodule

/* rtl/i2csb_in_stage.sv */
// Input register of the I2C slave buffer pointer block.
// Depends on i2csb_pkg.
module i2csb_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  i2csb_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            adv_i,
  output i2csb_pkg::item_t item_o
);
  import i2csb_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || adv_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

/* rtl/i2csb_core.sv */
// Pointer state, receive and transmit stores, and per-request decode.
// Depends on i2csb_pkg.
module i2csb_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  i2csb_pkg::item_t   item_i,
  output i2csb_pkg::result_t res_o,
  output i2csb_pkg::ptr_stat_t stat_o
);
  import i2csb_pkg::*;

  localparam logic [PTR_W:0] PTR_LAST = (PTR_W + 1)'(BUF_DEPTH - 1);

  logic [7:0]       rx_mem_q [BUF_DEPTH];
  logic [7:0]       tx_mem_q [BUF_DEPTH];
  logic             ptr_valid_q, ptr_valid_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;

  logic [PTR_W-1:0] ptr_eff;
  logic [PTR_W:0]   ptr_inc;
  logic [PTR_W-1:0] hidx;
  logic             hidx_ok;
  logic             rx_we, tx_we;
  result_t          res;

  assign ptr_eff = ptr_valid_q ? ptr_q : '0;
  assign ptr_inc = {1'b0, ptr_eff} + (PTR_W + 1)'(1);
  assign hidx    = PTR_W'(item_i.host_index);
  assign hidx_ok = {6'd0, item_i.host_index} < 9'(BUF_DEPTH);

  always_comb begin
    res         = '0;
    ptr_valid_d = ptr_valid_q;
    ptr_d       = ptr_q;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    if (item_i.opcode == OP_HOST_WR) begin
      tx_we = hidx_ok;
    end else if (item_i.opcode == OP_HOST_RD) begin
      res.host_data = hidx_ok ? rx_mem_q[hidx] : 8'd0;
    end else if (!item_i.hold_off) begin
      case (item_i.opcode)
        OP_ADDR_RX: begin
          res.event_flags = FLG_ADDR;
          res.bus_action  = ACT_ACK;
          ptr_valid_d     = 1'b0;
        end
        OP_DATA_RX: begin
          res.event_flags = FLG_DATA;
          if (!ptr_valid_q) begin
            ptr_d          = ({1'b0, item_i.data_byte} < 9'(BUF_DEPTH)) ?
                             PTR_W'(item_i.data_byte) : '0;
            ptr_valid_d    = 1'b1;
            res.bus_action = ACT_ACK;
          end else begin
            rx_we          = 1'b1;
            res.rx_written = 1'b1;
            if (ptr_inc < PTR_LAST) begin
              ptr_d          = ptr_inc[PTR_W-1:0];
              res.bus_action = ACT_ACK;
            end else begin
              res.event_flags = FLG_DATA | FLG_FULL;
              ptr_valid_d     = 1'b0;
              res.bus_action  = ACT_NACK;
            end
          end
        end
        OP_TX_REQ: begin
          if (!ptr_valid_q) begin
            res.event_flags = FLG_NOPTR;
          end
          res.send_byte = tx_mem_q[ptr_eff];
          if (ptr_inc < PTR_LAST) begin
            ptr_d           = ptr_inc[PTR_W-1:0];
            ptr_valid_d     = 1'b1;
            res.event_flags = res.event_flags | FLG_MORE;
            res.bus_action  = ACT_ACK;
          end else begin
            ptr_valid_d     = 1'b0;
            res.event_flags = res.event_flags | FLG_LAST;
            res.bus_action  = ACT_NACK;
          end
        end
        default: begin
          res.bus_action = ACT_RELEASE;
          ptr_valid_d    = 1'b0;
        end
      endcase
      if (!ptr_valid_d) begin
        ptr_d = '0;
      end
    end
  end

  assign res_o  = res;
  assign stat_o = '{ptr_valid: ptr_valid_q, ptr: ptr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_valid_q <= 1'b0;
      ptr_q       <= '0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
        rx_mem_q[i] <= 8'd0;
        tx_mem_q[i] <= 8'd0;
      end
    end else if (fire_i) begin
      ptr_valid_q <= ptr_valid_d;
      ptr_q       <= ptr_d;
      if (rx_we) begin
        rx_mem_q[ptr_q] <= item_i.data_byte;
      end
      if (tx_we) begin
        tx_mem_q[hidx] <= item_i.data_byte;
      end
    end
  end

endmodule

/* rtl/i2csb_out_stage.sv */
// Result register of the I2C slave buffer pointer block.
// Depends on i2csb_pkg.
module i2csb_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  i2csb_pkg::result_t res_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output i2csb_pkg::result_t res_o
);
  import i2csb_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* test/i2csb_checker.sv */
`timescale 1ns / 1ps
// Checker for the I2C slave buffer pointer: keeps its own pointer and both stores,
// predicts one result per accepted s_axis request and compares m_axis results in order.
// Depends on i2csb_pkg.
module i2csb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // data_byte[7:0], host_index[10:8], hold_off[11], zero fill
  input  logic [i2csb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [i2csb_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // bus_action[1:0], send_byte[9:2], event_flags[17:10], rx_written[18],
  // host_data[26:19], zero fill
  input  logic [i2csb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import i2csb_pkg::*;

  logic [7:0]  rx_mem [BUF_DEPTH];
  logic [7:0]  tx_mem [BUF_DEPTH];
  logic        ptr_ok;
  int unsigned ptr;
  result_t     due_q [$];
  int          fails;
  int          checked;
  int          pend;

  assign fail_count_o = fails;
  assign pending_o    = pend;
  assign checked_o    = checked;

  initial begin
    fails   = 0;
    checked = 0;
    pend    = 0;
  end

  function automatic result_t bus_step(logic [2:0] op, logic [7:0] dat,
                                       logic [2:0] idx, logic busy);
    result_t r;
    r = '0;
    if (op == OP_HOST_WR) begin
      if (idx < BUF_DEPTH) tx_mem[idx] = dat;
    end else if (op == OP_HOST_RD) begin
      if (idx < BUF_DEPTH) r.host_data = rx_mem[idx];
    end else if (!busy) begin
      case (op)
        OP_ADDR_RX: begin
          r.event_flags = r.event_flags | FLG_ADDR;
          r.bus_action  = ACT_ACK;
          ptr_ok        = 1'b0;
        end
        OP_DATA_RX: begin
          r.event_flags = r.event_flags | FLG_DATA;
          if (!ptr_ok) begin
            ptr          = (dat < BUF_DEPTH) ? dat : 0;
            ptr_ok       = 1'b1;
            r.bus_action = ACT_ACK;
          end else begin
            if (ptr < BUF_DEPTH) rx_mem[ptr] = dat;
            r.rx_written = 1'b1;
            ptr++;
            if (ptr < BUF_DEPTH - 1) begin
              r.bus_action = ACT_ACK;
            end else begin
              r.event_flags = r.event_flags | FLG_FULL;
              ptr_ok        = 1'b0;
              r.bus_action  = ACT_NACK;
            end
          end
        end
        OP_TX_REQ: begin
          if (!ptr_ok) begin
            ptr           = 0;
            ptr_ok        = 1'b1;
            r.event_flags = r.event_flags | FLG_NOPTR;
          end
          if (ptr < BUF_DEPTH) r.send_byte = tx_mem[ptr];
          ptr++;
          if (ptr < BUF_DEPTH - 1) begin
            r.event_flags = r.event_flags | FLG_MORE;
            r.bus_action  = ACT_ACK;
          end else begin
            r.event_flags = r.event_flags | FLG_LAST;
            ptr_ok        = 1'b0;
            r.bus_action  = ACT_NACK;
          end
        end
        default: begin
          r.bus_action = ACT_RELEASE;
          ptr_ok       = 1'b0;
        end
      endcase
      if (!ptr_ok) ptr = 0;
    end
    return r;
  endfunction

  function automatic int field_bad(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t              want;
    logic [M_TDATA_W-1:0] d;
    int                   i;
    if (!rst_ni) begin
      for (i = 0; i < BUF_DEPTH; i++) begin
        rx_mem[i] = '0;
        tx_mem[i] = '0;
      end
      ptr_ok = 1'b0;
      ptr    = 0;
      due_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        d = m_axis_tdata;
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, d);
          fails++;
        end else begin
          want = due_q.pop_front();
          fails += field_bad("bus_action", want.bus_action, d[1:0])
                 + field_bad("send_byte", want.send_byte, d[9:2])
                 + field_bad("event_flags", want.event_flags, d[17:10])
                 + field_bad("rx_written", want.rx_written, d[18])
                 + field_bad("host_data", want.host_data, d[26:19]);
          checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_q.push_back(bus_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[10:8],
                                 s_axis_tdata[11]));
    end
    pend = due_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the I2C slave buffer pointer: clock, reset, request stimulus with
// paced handshakes on both sides, and the verdict. Depends on i2csb_pkg and i2csb_checker.
module tb;
  import i2csb_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 210;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int fail_cnt;
  int pend_cnt;
  int checked_cnt;
  int cycles;
  int idle_pct;
  int stall_pct;
  int live_items;

  i2c_slave_buffer_pointer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  i2csb_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_cnt),
    .pending_o     (pend_cnt),
    .checked_o     (checked_cnt)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pend_cnt);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // one request; returns at the falling edge after it was taken
  task automatic put_request(logic [2:0] op, logic [7:0] dat, logic [2:0] idx, logic hold);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, hold, idx, dat};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (!hold || op == OP_HOST_WR || op == OP_HOST_RD) live_items++;
  endtask

  function automatic logic rare_hold();
    return ($urandom_range(0, 15) == 0);
  endfunction

  function automatic logic [2:0] end_code();
    int k;
    k = $urandom_range(0, 9);
    return (k == 0) ? OP_SPARE_A : (k == 1) ? OP_SPARE_B : OP_END;
  endfunction

  task automatic random_transfer();
    int kind;
    int n;
    int j;
    logic [7:0] p;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(1, 9);
    p    = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, BUF_DEPTH - 1))
                                      : 8'($urandom_range(0, 255));
    if (kind <= 4) begin
      put_request(OP_ADDR_RX, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  rare_hold());
      put_request(OP_DATA_RX, p, 3'($urandom_range(0, 7)), rare_hold());
      for (j = 0; j < n; j++)
        put_request(kind <= 2 ? OP_DATA_RX : OP_TX_REQ, 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)), rare_hold());
      put_request(end_code(), 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  rare_hold());
    end else if (kind == 5) begin
      for (j = 0; j < n; j++)
        put_request(OP_TX_REQ, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                    rare_hold());
      put_request(end_code(), 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  rare_hold());
    end else if (kind <= 7) begin
      for (j = 0; j < n / 2 + 1; j++)
        put_request(kind == 6 ? OP_HOST_WR : OP_HOST_RD, 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else begin
      for (j = 0; j < n / 2 + 1; j++)
        put_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int sender_idle, int receiver_stall);
    int goal;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    goal      = live_items + PHASE_ITEMS;
    while (live_items < goal) random_transfer();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cycles        = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    live_items    = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset contents, pointer bounds, full and last, busy, spare codes
    put_request(OP_TX_REQ,  8'h00, 3'd0, 1'b0);
    put_request(OP_HOST_WR, 8'hFF, 3'd0, 1'b0);
    put_request(OP_HOST_WR, 8'hA5, 3'd7, 1'b0);
    put_request(OP_HOST_RD, 8'h00, 3'd7, 1'b0);
    put_request(OP_ADDR_RX, 8'h00, 3'd0, 1'b0);
    put_request(OP_DATA_RX, 8'hFF, 3'd0, 1'b0);
    put_request(OP_DATA_RX, 8'h00, 3'd0, 1'b0);
    put_request(OP_DATA_RX, 8'hFF, 3'd0, 1'b1);
    put_request(OP_DATA_RX, 8'h5A, 3'd0, 1'b0);
    put_request(OP_END,     8'h00, 3'd0, 1'b0);
    put_request(OP_ADDR_RX, 8'h00, 3'd0, 1'b0);
    put_request(OP_DATA_RX, 8'h07, 3'd0, 1'b0);
    put_request(OP_DATA_RX, 8'h81, 3'd0, 1'b0);
    put_request(OP_DATA_RX, 8'h3C, 3'd0, 1'b0);
    put_request(OP_SPARE_A, 8'h00, 3'd0, 1'b0);
    put_request(OP_ADDR_RX, 8'h00, 3'd0, 1'b0);
    put_request(OP_DATA_RX, 8'h06, 3'd0, 1'b0);
    put_request(OP_TX_REQ,  8'h00, 3'd0, 1'b0);
    put_request(OP_TX_REQ,  8'h00, 3'd0, 1'b0);
    put_request(OP_SPARE_B, 8'h00, 3'd0, 1'b0);
    put_request(OP_HOST_RD, 8'h00, 3'd7, 1'b1);
    put_request(OP_HOST_RD, 8'h00, 3'd0, 1'b0);
    put_request(OP_ADDR_RX, 8'h00, 3'd0, 1'b1);
    put_request(OP_TX_REQ,  8'h00, 3'd0, 1'b1);
    put_request(OP_END,     8'h00, 3'd0, 1'b1);

    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(11, 11);
    s_axis_tvalid <= 1'b0;

    while (pend_cnt != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("sent %0d live requests (bus, host, busy and spare codes) under four pacing phases",
             live_items);
    $display("compared %0d results in %0d cycles", checked_cnt, cycles);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/i2csb_pkg.sv
rtl/i2csb_in_stage.sv
rtl/i2csb_core.sv
rtl/i2csb_out_stage.sv
rtl/i2c_slave_buffer_pointer.sv
test/i2csb_checker.sv
test/tb.sv
